// File: hdl/tpc_pkg.sv
`timescale 1ns / 1ps

package tpc_pkg;

    // Widths of the fields as they appear on the ports.
    localparam int SAMPLE_W     = 16;
    localparam int PEAK_COUNT_W = 16;

    // Samples seen in a run, saturating at three.
    localparam logic [1:0] SEEN_NONE  = 2'd0;
    localparam logic [1:0] SEEN_FIRST = 2'd1;
    localparam logic [1:0] SEEN_TWO   = 2'd2;
    localparam logic [1:0] RUN_FULL   = 2'd3;

    typedef struct packed {
        logic [PEAK_COUNT_W-1:0] peak_count;
        logic                    too_short;
    } t_result;

endpackage

// File: hdl/tpc_core.sv
`timescale 1ns / 1ps

module tpc_core
    import tpc_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_is_last,
    input  logic                   i_cfg_we,
    input  logic [SAMPLE_BITS-1:0] i_cfg_data,
    output logic                   o_res_strobe,
    output t_result                o_res
);

    logic signed [SAMPLE_BITS-1:0] r_older, n_older;
    logic signed [SAMPLE_BITS-1:0] r_newer, n_newer;
    logic signed [SAMPLE_BITS-1:0] r_min_peak;
    logic [1:0]                    r_seen, n_seen;
    logic [COUNT_BITS-1:0]         r_peaks, n_peaks;

    logic signed [SAMPLE_BITS-1:0] w_cur;
    logic                          w_prev_peak;
    logic                          w_last_peak;
    logic                          w_too_short;
    logic [1:0]                    w_inc;
    logic [COUNT_BITS:0]           w_sum;
    logic [COUNT_BITS-1:0]         w_sat;

    assign w_cur = $signed(i_sample);

    // The previous sample can only be judged now that its right-hand neighbour is here.
    always_comb begin
        w_prev_peak = 1'b0;
        if (r_seen == SEEN_FIRST) begin
            w_prev_peak = (r_newer > w_cur) && (r_newer >= r_min_peak);
        end else if (r_seen == SEEN_TWO || r_seen == RUN_FULL) begin
            w_prev_peak = (r_older < r_newer) && (r_newer > w_cur)
                          && (r_newer >= r_min_peak);
        end
    end

    assign w_too_short = (r_seen == SEEN_NONE) || (r_seen == SEEN_FIRST);
    assign w_last_peak = i_is_last && !w_too_short && (w_cur > r_newer)
                         && (w_cur >= r_min_peak);

    // Two saturating increments in a row give the same as one clamped sum.
    assign w_inc = {1'b0, w_prev_peak} + {1'b0, w_last_peak};
    assign w_sum = {1'b0, r_peaks} + (COUNT_BITS+1)'(w_inc);
    assign w_sat = w_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : w_sum[COUNT_BITS-1:0];

    assign o_res_strobe     = i_accept && i_is_last;
    assign o_res.too_short  = w_too_short;
    assign o_res.peak_count = w_too_short ? '0 : PEAK_COUNT_W'(w_sat);

    always_comb begin
        n_older = r_older;
        n_newer = r_newer;
        n_seen  = r_seen;
        n_peaks = r_peaks;
        if (i_accept) begin
            if (i_is_last) begin
                n_older = '0;
                n_newer = '0;
                n_seen  = SEEN_NONE;
                n_peaks = '0;
            end else begin
                n_older = r_newer;
                n_newer = w_cur;
                n_seen  = (r_seen == RUN_FULL) ? RUN_FULL : r_seen + 2'd1;
                n_peaks = w_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older    <= '0;
            r_newer    <= '0;
            r_seen     <= SEEN_NONE;
            r_peaks    <= '0;
            r_min_peak <= '0;
        end else begin
            r_older <= n_older;
            r_newer <= n_newer;
            r_seen  <= n_seen;
            r_peaks <= n_peaks;
            if (i_cfg_we) begin
                r_min_peak <= $signed(i_cfg_data);
            end
        end
    end

endmodule

// File: hdl/tpc_out_reg.sv
`timescale 1ns / 1ps

module tpc_out_reg
    import tpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: hdl/thresholded_peak_counter_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_ready      i_sample, i_is_last
// result    out        o_out_valid / i_out_ready    o_peak_count, o_too_short
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_data (min_peak)
//
// One item is taken every cycle while the input is not stalled; a result appears in
// the output register in the cycle after the last item of a run is accepted.
// The rate is set by the single output register: input stalls only while a
// result sits there unclaimed. Configuration writes are always taken.
// Synchronous active-low reset clears the run history, min_peak and the result valid.

module thresholded_peak_counter_top
    import tpc_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                    i_is_last,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [PEAK_COUNT_W-1:0] o_peak_count,
    output logic                    o_too_short,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic signed [SAMPLE_W-1:0] i_cfg_data
);

    logic    w_accept;
    logic    w_res_strobe;
    t_result w_res;
    t_result w_out;

    assign o_in_ready  = !o_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;

    tpc_core #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_sample     (SAMPLE_BITS'($unsigned(i_sample))),
        .i_is_last    (i_is_last),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (SAMPLE_BITS'($unsigned(i_cfg_data))),
        .o_res_strobe (w_res_strobe),
        .o_res        (w_res)
    );

    tpc_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_strobe),
        .i_res   (w_res),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_res   (w_out)
    );

    assign o_peak_count = w_out.peak_count;
    assign o_too_short  = w_out.too_short;

endmodule

// File: hdl/tpc_checker.sv
`timescale 1ns / 1ps

module tpc_checker
    import tpc_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic                    i_is_last,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic [PEAK_COUNT_W-1:0] o_peak_count,
    input logic                    o_too_short
);

    // A short run never reports a count.
    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_too_short |-> o_peak_count == '0)
        else $error("too_short result with non-zero peak_count");

    // A waiting result must not be overtaken by a new input item.
    a_block_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted while result is stalled");

    // The last item of a run yields a result on the next cycle.
    a_last_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_is_last |=> o_out_valid)
        else $error("no result after last item");

    // Intermediate items never raise a new result.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_valid && o_in_ready && i_is_last) && (!o_out_valid || i_out_ready)
        |=> !o_out_valid)
        else $error("result without a last item");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid
        && $stable(o_peak_count) && $stable(o_too_short))
        else $error("stalled result changed");

endmodule

bind thresholded_peak_counter_top tpc_checker u_tpc_checker (.*);
